// ----- hw/rtl/cdad_pkg.sv -----
// Shared types, constants and calendar helper functions for the date adder.
// Used by cdad_ctrl, cdad_dp and calendar_date_add_days_core.
`timescale 1ns / 1ps
`default_nettype none

package cdad_pkg;

  localparam int unsigned DAY_W      = 5;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned YEAR_W     = 14;
  // Internal year register: holds any reachable year up to the largest limit.
  localparam int unsigned YEAR_REG_W = 16;
  localparam int unsigned PROD_W     = 27;

  typedef logic [DAY_W-1:0]      day_t;
  typedef logic [MONTH_W-1:0]    month_t;
  typedef logic [YEAR_W-1:0]     year_t;
  typedef logic [YEAR_REG_W-1:0] year_reg_t;
  typedef logic [PROD_W-1:0]     prod_t;

  // Year divided by 100 through a reciprocal that never overestimates,
  // followed by a single correction step.
  localparam logic [12:0] DIV100_MUL   = 13'd5242;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [13:0] CENTURY      = 14'd100;
  localparam logic [6:0]  LAST_YR100   = 7'd99;

  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_APR = 4'd4;
  localparam month_t MONTH_JUN = 4'd6;
  localparam month_t MONTH_SEP = 4'd9;
  localparam month_t MONTH_NOV = 4'd11;
  localparam month_t MONTH_DEC = 4'd12;

  localparam day_t DAYS_28 = 5'd28;
  localparam day_t DAYS_29 = 5'd29;
  localparam day_t DAYS_30 = 5'd30;
  localparam day_t DAYS_31 = 5'd31;
  localparam day_t FIRST_DAY = 5'd1;

  typedef struct packed {
    logic load;   // capture a new request
    logic mul;    // start the year / 100 reduction
    logic div;    // finish the reduction
    logic check;  // latch the validity of the start date
    logic step;   // advance by one month, or add the last days
    logic emit;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic invalid;  // start date is not a valid date
    logic last;     // the current step finishes the walk
  } status_t;

  // Leap rule from the year within its century and the century modulo 4.
  function automatic logic leap_year(input logic [6:0] yr100, input logic [1:0] cent4);
    logic leap;
    leap = ((yr100[1:0] == 2'd0) && (yr100 != 7'd0)) ||
           ((yr100 == 7'd0) && (cent4 == 2'd0));
    return leap;
  endfunction

  function automatic day_t month_length(input month_t m, input logic leap);
    day_t len;
    case (m) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_30;
      MONTH_FEB: len = leap ? DAYS_29 : DAYS_28;
      default:   len = DAYS_31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdad_dp.sv -----
// Datapath of the date adder: date, remaining day count, century tracking
// and the output register. Depends on cdad_pkg; driven by cdad_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module cdad_dp #(
  parameter int unsigned DAYS_WIDTH = 16,
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  wire                        clk,
  input  wire cdad_pkg::cmd_t        cmd,
  output cdad_pkg::status_t          sts,
  input  wire cdad_pkg::day_t        start_day,
  input  wire cdad_pkg::month_t      start_month,
  input  wire cdad_pkg::year_t       start_year,
  input  wire [DAYS_WIDTH-1:0]       days_to_add,
  output cdad_pkg::day_t             new_day,
  output cdad_pkg::month_t           new_month,
  output cdad_pkg::year_t            new_year,
  output logic                       overflowed,
  output logic                       input_invalid
);

  localparam cdad_pkg::year_reg_t LIMIT = cdad_pkg::year_reg_t'(YEAR_LIMIT);

  cdad_pkg::day_t      d;
  cdad_pkg::month_t    m;
  cdad_pkg::year_reg_t y;
  logic [DAYS_WIDTH-1:0] n;
  cdad_pkg::prod_t     prod;
  logic [6:0]          yr100;
  logic [1:0]          cent4;
  logic                ovf;
  logic                inv;

  logic                leap;
  cdad_pkg::day_t      mlen;
  cdad_pkg::day_t      left;
  logic [5:0]          step_len;
  logic                fits;
  logic                sat;
  logic [7:0]          q_est;
  logic [13:0]         r_wide;
  logic [7:0]          r_est;

  always_comb begin
    leap     = cdad_pkg::leap_year(yr100, cent4);
    mlen     = cdad_pkg::month_length(m, leap);
    left     = mlen - d;
    step_len = {1'b0, left} + 6'd1;
    fits     = n <= DAYS_WIDTH'(left);
    sat      = (m == cdad_pkg::MONTH_DEC) && (y >= LIMIT);
    sts.last = fits || sat;
    sts.invalid = (m == 4'd0) || (m > cdad_pkg::MONTH_DEC) || (y > LIMIT) ||
                  (d == 5'd0) || (d > mlen);
    q_est  = prod[cdad_pkg::PROD_W-1:cdad_pkg::DIV100_SHIFT];
    r_wide = y[13:0] - 14'(q_est) * cdad_pkg::CENTURY;
    r_est  = r_wide[7:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d   <= start_day;
      m   <= start_month;
      y   <= cdad_pkg::year_reg_t'(start_year);
      n   <= days_to_add;
      ovf <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= cdad_pkg::prod_t'(y[13:0]) * cdad_pkg::prod_t'(cdad_pkg::DIV100_MUL);
    end
    if (cmd.div) begin
      // The estimate is the true quotient or one less.
      if (r_est >= 8'(cdad_pkg::CENTURY)) begin
        yr100 <= 7'(r_est - 8'(cdad_pkg::CENTURY));
        cent4 <= q_est[1:0] + 2'd1;
      end else begin
        yr100 <= r_est[6:0];
        cent4 <= q_est[1:0];
      end
    end
    if (cmd.check) begin
      inv <= sts.invalid;
    end
    if (cmd.step) begin
      if (fits) begin
        d <= d + n[4:0];
      end else begin
        n <= n - DAYS_WIDTH'(step_len);
        if (m == cdad_pkg::MONTH_DEC) begin
          if (sat) begin
            d   <= cdad_pkg::DAYS_31;
            y   <= LIMIT;
            ovf <= 1'b1;
          end else begin
            d <= cdad_pkg::FIRST_DAY;
            m <= cdad_pkg::MONTH_JAN;
            y <= y + 16'd1;
            if (yr100 == cdad_pkg::LAST_YR100) begin
              yr100 <= 7'd0;
              cent4 <= cent4 + 2'd1;
            end else begin
              yr100 <= yr100 + 7'd1;
            end
          end
        end else begin
          d <= cdad_pkg::FIRST_DAY;
          m <= m + 4'd1;
        end
      end
    end
    if (cmd.emit) begin
      new_day       <= d;
      new_month     <= m;
      new_year      <= y[13:0];
      overflowed    <= ovf;
      input_invalid <= inv;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cdad_ctrl.sv -----
// Controller of the date adder: sequences setup, the month walk and the
// output handshake. Depends on cdad_pkg; commands cdad_dp.
`timescale 1ns / 1ps
`default_nettype none

module cdad_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cdad_pkg::cmd_t         cmd,
  input  wire cdad_pkg::status_t sts
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_CHECK  = 6'b001000,
    ST_STEP   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  always_comb begin
    out_free   = !out_valid || out_ready;
    in_ready   = (state == ST_IDLE);
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.invalid ? ST_FINISH : ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/calendar_date_add_days_core.sv -----
// Top level of the Gregorian date adder: controller plus datapath.
// Depends on cdad_pkg, cdad_ctrl and cdad_dp.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     start_day, start_month, start_year, days_to_add
//   out      out_valid / out_ready   new_day, new_month, new_year, overflowed,
//                                    input_invalid
//
// A request passes the MUL, DIV and CHECK setup states, then walks month by month
// in ST_STEP through the single month-step unit and emits in ST_FINISH.
// An invalid start date skips the walk. Reset is synchronous and clears only
// control state. A new request is taken while the previous result waits in
// the output register; a stalled output holds the controller in ST_FINISH.
`timescale 1ns / 1ps
`default_nettype none

module calendar_date_add_days_core #(
  parameter int unsigned DAYS_WIDTH = 16,
  parameter int unsigned YEAR_LIMIT = 9999
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire cdad_pkg::day_t   start_day,
  input  wire cdad_pkg::month_t start_month,
  input  wire cdad_pkg::year_t  start_year,
  input  wire [DAYS_WIDTH-1:0]  days_to_add,
  output logic                  out_valid,
  input  wire                   out_ready,
  output cdad_pkg::day_t        new_day,
  output cdad_pkg::month_t      new_month,
  output cdad_pkg::year_t       new_year,
  output logic                  overflowed,
  output logic                  input_invalid
);

  cdad_pkg::cmd_t    cmd;
  cdad_pkg::status_t sts;

  cdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  cdad_dp #(
    .DAYS_WIDTH (DAYS_WIDTH),
    .YEAR_LIMIT (YEAR_LIMIT)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .sts           (sts),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .days_to_add   (days_to_add),
    .new_day       (new_day),
    .new_month     (new_month),
    .new_year      (new_year),
    .overflowed    (overflowed),
    .input_invalid (input_invalid)
  );

endmodule

`default_nettype wire
